// ===== design/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg: shared definitions for the rate-monotonic tick scheduler
// Widths, register map codes and the task selection record.
// ----------------------------------------------------------------------------
`default_nettype none

package rmts_pkg;

	localparam int TASK_SLOTS = 4;   // slots in the register map
	localparam int TASK_W     = 2;   // task index width
	localparam int WORD_W     = 16;  // burst, period, phase and work width
	localparam int TIME_W     = 32;  // tick counter width
	localparam int CFG_IDX_W  = 3;   // register index width

	// register map: bursts first, then periods
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 3'd4;

	// one selection; idle counts as a selection of its own
	typedef struct packed {
		logic              idle;
		logic [TASK_W-1:0] idx;
	} pick_t;

endpackage

`default_nettype wire

// ===== design/rate_monotonic_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_top: preemptive rate-monotonic tick scheduler
// One item is one timer tick; one result item comes back per tick.
// ----------------------------------------------------------------------------
// Each accepted item is a timer tick. On a tick every used task whose phase
// counter is at zero is released (its remaining work reloaded from its
// burst), then the ready task with the smallest period is granted one unit of
// work, lowest index winning ties. The result gives the tick number, the
// granted task (0 when idle), an idle flag and whether the grant differs from
// the previous tick's, idle being a grant of its own. A period of zero marks
// an unused slot. A tick with restart set first clears time, phases and
// remaining work; the previous grant is kept for the switch flag.
// Ticks are taken one item per clock cycle while the result side does not
// stall. A tick passes from the input register through the single-pass
// state update into the result register: the release, the four-way priority
// compare and the work decrement all sit between the two. The result register
// decouples the sides, so a tick is taken while a result still waits.
// Configuration (index 0..3 bursts, 4..7 periods) is to be written only while
// idle; the user is bound to this, the block does not enforce it. Writes to
// slots at or beyond NUM_TASKS are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_monotonic_tick_scheduler_top
	import rmts_pkg::*;
#(
	parameter int NUM_TASKS = TASK_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// tick items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TIME_W-1:0]    time_now,
	output logic [TASK_W-1:0]    running_task,
	output logic                 cpu_idle,
	output logic                 switched
);

	// configuration registers
	logic [WORD_W-1:0] burst_q  [NUM_TASKS];
	logic [WORD_W-1:0] period_q [NUM_TASKS];

	// scheduler state
	logic [TIME_W-1:0] tick_q;
	logic [WORD_W-1:0] phase_q [NUM_TASKS];
	logic [WORD_W-1:0] work_q  [NUM_TASKS];
	pick_t             last_q;

	// input stage
	logic valid_s1;
	logic restart_s1;

	// result stage
	logic              valid_s2;
	logic [TIME_W-1:0] time_s2;
	logic [TASK_W-1:0] task_s2;
	logic              idle_s2;
	logic              switched_s2;

	// single-pass update signals
	logic              adv;
	logic [TIME_W-1:0] tick_cur;
	logic [WORD_W-1:0] ph_cur   [NUM_TASKS];
	logic [WORD_W-1:0] wk_rel   [NUM_TASKS];
	logic [WORD_W-1:0] ph_next  [NUM_TASKS];
	logic [WORD_W-1:0] wk_next  [NUM_TASKS];
	logic [NUM_TASKS-1:0] ready;
	pick_t             pick;
	logic              sw;

	// the tick in s1 moves on when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// ---------------------------------------------------------------- config
	for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				burst_q[g]  <= '0;
				period_q[g] <= '0;
			end else if (cfg_we) begin
				if (cfg_index == CFG_BURST_BASE + CFG_IDX_W'(g))
					burst_q[g] <= cfg_data;
				if (cfg_index == CFG_PERIOD_BASE + CFG_IDX_W'(g))
					period_q[g] <= cfg_data;
			end
		end
	end

	// ----------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			restart_s1 <= restart;
	end

	// -------------------------------------------------- release and advance
	// restart clears time, phases and work ahead of this tick's release
	assign tick_cur = restart_s1 ? '0 : tick_q;

	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			ph_cur[i] = restart_s1 ? '0 : phase_q[i];
			if (period_q[i] == '0) begin
				// unused slot: no release, phase pinned at zero
				wk_rel[i]  = restart_s1 ? '0 : work_q[i];
				ph_next[i] = '0;
			end else begin
				wk_rel[i] = (ph_cur[i] == '0) ? burst_q[i]
				                              : (restart_s1 ? '0 : work_q[i]);
				// also wraps a phase left beyond a shortened period
				if (({1'b0, ph_cur[i]} + {{WORD_W{1'b0}}, 1'b1}) >= {1'b0, period_q[i]})
					ph_next[i] = '0;
				else
					ph_next[i] = ph_cur[i] + WORD_W'(1);
			end
			ready[i] = (period_q[i] != '0) && (wk_rel[i] != '0);
		end
	end

	rmts_pick #(
		.NUM_TASKS (NUM_TASKS)
	) u_pick (
		.ready  (ready),
		.period (period_q),
		.pick   (pick)
	);

	assign sw = (pick.idle != last_q.idle) || (!pick.idle && pick.idx != last_q.idx);

	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (!pick.idle && pick.idx == TASK_W'(i))
				wk_next[i] = wk_rel[i] - WORD_W'(1);
			else
				wk_next[i] = wk_rel[i];
		end
	end

	// ----------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			last_q.idle <= 1'b1;
			last_q.idx  <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				phase_q[i] <= '0;
				work_q[i]  <= '0;
			end
		end else if (adv) begin
			tick_q <= tick_cur + TIME_W'(1);
			last_q <= pick;
			for (int i = 0; i < NUM_TASKS; i++) begin
				phase_q[i] <= ph_next[i];
				work_q[i]  <= wk_next[i];
			end
		end
	end

	// ---------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			time_s2     <= tick_cur;
			task_s2     <= pick.idle ? '0 : pick.idx;
			idle_s2     <= pick.idle;
			switched_s2 <= sw;
		end
	end

	assign out_valid    = valid_s2;
	assign time_now     = time_s2;
	assign running_task = task_s2;
	assign cpu_idle     = idle_s2;
	assign switched     = switched_s2;

`ifndef SYNTH
	// an idle result always reports task zero
	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && idle_s2 |-> task_s2 == '0)
		else $error("idle result with non-zero task");

	// a restarted tick describes time zero
	a_restart_time: assert property (@(posedge clk) disable iff (!arst_n)
		adv && restart_s1 |=> time_s2 == '0)
		else $error("restart tick not at time zero");

	// a held tick keeps its restart flag
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(restart_s1))
		else $error("input stage lost its item");

	// a pending result matches the remembered grant
	a_last_grant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !idle_s2 |-> !last_q.idle && last_q.idx == task_s2)
		else $error("result grant and last grant disagree");
`endif

endmodule

`default_nettype wire

// ===== design/rmts_pick.sv =====
// ----------------------------------------------------------------------------
// rmts_pick: rate-monotonic priority selection
// Picks the ready task with the smallest period, lowest index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module rmts_pick
	import rmts_pkg::*;
#(
	parameter int NUM_TASKS = TASK_SLOTS
) (
	input  logic [NUM_TASKS-1:0] ready,
	input  logic [WORD_W-1:0]    period [NUM_TASKS],
	output pick_t                pick
);

	logic [WORD_W-1:0] best;

	// at most four dependent steps on 16-bit values
	always_comb begin
		pick.idle = 1'b1;
		pick.idx  = '0;
		best      = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (ready[i] && (pick.idle || period[i] < best)) begin
				pick.idle = 1'b0;
				pick.idx  = TASK_W'(i);
				best      = period[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the rate-monotonic tick scheduler
// Ticks go in through a valid/ready channel with random gaps. Each result
// item is checked against an in-bench schedule predictor.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the registers, tick counter, phase
// counters, remaining work and last grant. The sender works out the expected
// grant when a tick is accepted and queues it; the checker pops the oldest
// entry for every accepted result item and compares field by field.
// Registers are only written with the block drained.
// ----------------------------------------------------------------------------

module tb_top;
	import rmts_pkg::*;

	localparam int SLOTS     = TASK_SLOTS;
	localparam int MAX_GAP   = 17;
	localparam int SETTLE    = 4;          // cycles after the last result
	localparam int HOLD_LEN  = 80;         // long receiver stall
	localparam int RND_PHASE = 7;
	localparam int RND_TICKS = 100;

	// expected content of one result item
	typedef struct packed {
		logic [TIME_W-1:0] when;
		logic [TASK_W-1:0] slot;
		logic              idle;
		logic              sw;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 restart = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [TIME_W-1:0]    time_now;
	logic [TASK_W-1:0]    running_task;
	logic                 cpu_idle;
	logic                 switched;

	rate_monotonic_tick_scheduler_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.time_now    (time_now),
		.running_task(running_task),
		.cpu_idle    (cpu_idle),
		.switched    (switched)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: register copies plus the scheduler's own state
	logic [WORD_W-1:0] burst_m [SLOTS];
	logic [WORD_W-1:0] period_m [SLOTS];
	logic [TIME_W-1:0] tick_m;
	logic [WORD_W-1:0] phase_m [SLOTS];
	logic [WORD_W-1:0] work_m [SLOTS];
	pick_t             last_pick_m;

	grant_t grant_q[$];

	// pacing controls
	bit snd_quiet = 1'b0;    // sender never pauses
	bit rcv_quiet = 1'b0;    // receiver never stalls
	int hold_len  = 0;       // one long receiver stall, picked up by the receiver

	// bookkeeping
	int err_count = 0;
	int n_ticks = 0, n_restarts = 0, n_checked = 0, n_idle = 0, n_switch = 0;

	// one tick of the schedule: release, pick by shortest period, run one unit
	function automatic grant_t schedule_tick(input logic rst);
		pick_t             pick;
		logic [WORD_W-1:0] best;
		grant_t            g;

		if (rst) begin
			tick_m = '0;
			for (int i = 0; i < SLOTS; i++) begin
				phase_m[i] = '0;
				work_m[i]  = '0;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (period_m[i] == '0) begin
				phase_m[i] = '0;
			end else begin
				if (phase_m[i] == '0)
					work_m[i] = burst_m[i];
				// counter past a shrunk period wraps on this advance
				if (phase_m[i] + 17'd1 >= {1'b0, period_m[i]})
					phase_m[i] = '0;
				else
					phase_m[i] = phase_m[i] + 16'd1;
			end
		end
		pick.idle = 1'b1;
		pick.idx  = '0;
		best      = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (period_m[i] != '0 && work_m[i] != '0 && (pick.idle || period_m[i] < best)) begin
				pick.idle = 1'b0;
				pick.idx  = TASK_W'(i);
				best      = period_m[i];
			end
		end
		g.when = tick_m;
		g.slot = pick.idx;
		g.idle = pick.idle;
		g.sw   = (pick != last_pick_m);
		last_pick_m = pick;
		if (!pick.idle)
			work_m[pick.idx] = work_m[pick.idx] - 16'd1;
		tick_m = tick_m + 1'b1;
		return g;
	endfunction

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// --- stimulus helpers ---------------------------------------------------

	// one register write; cfg_we is dropped by cfg_close after a batch
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx < CFG_PERIOD_BASE)
			burst_m[idx - CFG_BURST_BASE] = val;
		else
			period_m[idx - CFG_PERIOD_BASE] = val;
	endtask

	task automatic cfg_close();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_slot(input int s, input logic [WORD_W-1:0] burst,
	                         input logic [WORD_W-1:0] period);
		cfg_write(CFG_BURST_BASE + CFG_IDX_W'(s), burst);
		cfg_write(CFG_PERIOD_BASE + CFG_IDX_W'(s), period);
	endtask

	// offer one tick; valid stays high straight into the next item on a zero gap
	task automatic send_tick(input logic rst);
		int gap;
		gap = draw_gap(snd_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		do @(posedge clk); while (!in_ready);
		grant_q.push_back(schedule_tick(rst));
		n_ticks++;
		if (rst)
			n_restarts++;
	endtask

	// stop offering, wait for every result, then let the pipe settle
	task automatic drain_ticks();
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_period();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WORD_W'($urandom_range(0, 65535));
			2:       return '1;
			default: return WORD_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_burst();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WORD_W'($urandom_range(0, 65535));
			2:       return '1;
			default: return WORD_W'($urandom_range(1, 5));
		endcase
	endfunction

	// --- tests --------------------------------------------------------------

	// all registers at zero: every slot unused, so the CPU idles
	task automatic test_idle_after_reset();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_ticks();
	endtask

	// equal periods go to the lower index, a shorter period preempts,
	// an unused slot with a full burst is never granted
	task automatic test_priority_and_ties();
		load_slot(0, 16'd2, 16'd4);
		load_slot(1, 16'd3, 16'd4);
		load_slot(2, 16'd1, 16'd2);
		load_slot(3, 16'hFFFF, 16'd0);
		cfg_close();
		for (int i = 0; i < 9; i++)
			send_tick(i == 6);
		drain_ticks();
	endtask

	// zero burst, period 1, the widest period and burst, then a period
	// shrunk below a running phase counter
	task automatic test_period_change();
		load_slot(0, 16'd0, 16'd1);
		load_slot(1, 16'hFFFF, 16'hFFFF);
		load_slot(2, 16'd1, 16'd10);
		load_slot(3, 16'd0, 16'd0);
		cfg_close();
		repeat (5) send_tick(1'b0);
		drain_ticks();
		cfg_write(CFG_PERIOD_BASE + CFG_IDX_W'(2), 16'd3);
		cfg_write(CFG_PERIOD_BASE + CFG_IDX_W'(1), 16'd0);
		cfg_close();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain_ticks();
	endtask

	// random task sets, mostly short periods and bursts so releases recur
	task automatic test_random_schedules();
		for (int ph = 0; ph < RND_PHASE; ph++) begin
			snd_quiet = (ph == 2 || ph == 5);
			rcv_quiet = (ph == 2 || ph == 4);
			for (int s = 0; s < SLOTS; s++)
				load_slot(s, rand_burst(), rand_period());
			cfg_close();
			for (int i = 0; i < RND_TICKS; i++)
				send_tick($urandom_range(0, 39) == 0);
			drain_ticks();
		end
		snd_quiet = 1'b0;
		rcv_quiet = 1'b0;
	endtask

	// receiver stalls for a long stretch while ticks keep coming back to back
	task automatic test_backpressure();
		load_slot(0, 16'd1, 16'd3);
		load_slot(1, 16'd2, 16'd5);
		load_slot(2, 16'd3, 16'd7);
		load_slot(3, 16'd4, 16'd11);
		cfg_close();
		snd_quiet = 1'b1;
		hold_len  = HOLD_LEN;
		repeat (40) send_tick(1'b0);
		drain_ticks();
		snd_quiet = 1'b0;
	endtask

	// --- result side --------------------------------------------------------

	// receiver: random stall before each result item, or the long hold
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall    = (hold_len != 0) ? hold_len : draw_gap(rcv_quiet);
			hold_len = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic cmp_field(input string name, input logic [TIME_W-1:0] want,
	                         input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// checker: every accepted result item against the oldest expected grant
	always @(posedge clk) begin : result_check
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_q.size() == 0) begin
				$error("result item with no tick outstanding (time_now %0d)", time_now);
				err_count++;
			end else begin
				want = grant_q.pop_front();
				cmp_field("time_now", want.when, time_now);
				cmp_field("running_task", TIME_W'(want.slot), TIME_W'(running_task));
				cmp_field("cpu_idle", TIME_W'(want.idle), TIME_W'(cpu_idle));
				cmp_field("switched", TIME_W'(want.sw), TIME_W'(switched));
				n_checked++;
				if (cpu_idle)
					n_idle++;
				if (switched)
					n_switch++;
			end
		end
	end

	// --- sequence -----------------------------------------------------------

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			burst_m[i]  = '0;
			period_m[i] = '0;
			phase_m[i]  = '0;
			work_m[i]   = '0;
		end
		tick_m      = '0;
		last_pick_m = '{idle: 1'b1, idx: '0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_after_reset();
		test_priority_and_ties();
		test_period_change();
		test_random_schedules();
		test_backpressure();

		if (grant_q.size() != 0) begin
			$error("%0d expected results never arrived", grant_q.size());
			err_count++;
		end
		$display("Run covered %0d ticks (%0d with restart), %0d results checked.",
		         n_ticks, n_restarts, n_checked);
		$display("Results: %0d idle, %0d grant switches, %0d errors.",
		         n_idle, n_switch, err_count);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(400_000 * 10);
		$display("Timed out waiting on a handshake");
		$display("TEST FAILED");
		$finish;
	end

endmodule
